>>> rtl/core/sbf_pkg.sv
`default_nettype none

package sbf_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned DIFF_W   = 33;
    localparam int unsigned SUMSQ_W  = 66;
    localparam int unsigned SQ_STEPS = 33;
    localparam int unsigned SQ_REM_W = 36;
    localparam int unsigned DV_STEPS = 32;
    localparam int unsigned MK_W     = 65;
    localparam int unsigned NUM_W    = 98;
    localparam int unsigned ADDR_W   = 4;

    localparam logic [1:0] REG_SPRING_K  = 2'd0;
    localparam logic [1:0] REG_REST_LEN  = 2'd1;
    localparam logic [1:0] REG_BUNGEE    = 2'd2;

    localparam logic [WORD_W-1:0] K_RESET      = 32'h0001_0000;
    localparam logic [WORD_W-1:0] POS_LIMIT    = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] NEG_LIMIT    = 32'h8000_0000;

endpackage

`default_nettype wire

>>> rtl/core/spring_bungee_force.sv
// spring_bungee_force: 2d hooke spring / bungee force on one particle
//
// input stream s_axis: one request per beat holds the particle and partner
// positions (signed fixed point with FRAC_BITS fraction bits). output stream
// m_axis: one result per request, in order, with the force components and
// the applied / saturated flags in tuser.
// registers (apb, pready always high): 0x0 spring constant, 0x4 rest length,
// 0x8 bungee mode. write them only while no request is in flight.
//
// from request accept to result valid the pipe runs through: input,
// squares, sum, 33 square root stages (one root bit each), five force
// product stages, 32 divider stages (one quotient bit each) and the output
// register. throughput is one request per cycle unless the pipe stalls.
// all stages advance together; when the receiver stalls a full output
// register, the whole pipe holds and s_axis_tready drops, nothing is lost
// or repeated. reset (synchronous, active low) empties the pipe and loads
// the register defaults (k = 1.0, rest length 0, spring mode).
`default_nettype none

module spring_bungee_force #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // particle_x, particle_y, partner_x, partner_y (32 bits each)
    input  wire logic [127:0]                 s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // force_x, force_y (32 bits each)
    output logic [63:0]                       m_axis_tdata,
    // applied, saturated
    output logic [1:0]                        m_axis_tuser,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [sbf_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import sbf_pkg::*;

    localparam int unsigned DW   = DIFF_W + FRAC_BITS;
    localparam int unsigned NST  = 74;
    localparam int unsigned ST_OUT = NST - 1;

    logic                 en;
    logic [NST-1:0]       r_vld;

    logic [WORD_W-1:0]    r_k;
    logic [WORD_W-1:0]    r_l0;
    logic                 r_bungee;

    // config
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k      <= K_RESET;
            r_l0     <= '0;
            r_bungee <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_SPRING_K: r_k      <= pwdata;
                REG_REST_LEN: r_l0     <= pwdata;
                REG_BUNGEE:   r_bungee <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SPRING_K: prdata = r_k;
            REG_REST_LEN: prdata = r_l0;
            REG_BUNGEE:   prdata = {31'd0, r_bungee};
            default:      prdata = '0;
        endcase
    end

    // pipeline control
    assign en            = !r_vld[ST_OUT] || m_axis_tready;
    assign s_axis_tready = en && i_rst_n;
    assign m_axis_tvalid = r_vld[ST_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], s_axis_tvalid};
        end
    end

    // stage a: differences
    logic signed [DIFF_W-1:0] r_a_dx, r_a_dy;
    // stage b: squares
    logic signed [DIFF_W-1:0] r_b_dx, r_b_dy;
    logic [SUMSQ_W-1:0]       r_b_sx, r_b_sy;
    // square root chain, entry 0 is the sum stage
    logic [SQ_REM_W-1:0]      r_sq_rem  [0:SQ_STEPS];
    logic [DIFF_W-1:0]        r_sq_root [0:SQ_STEPS];
    logic [SUMSQ_W-1:0]       r_sq_rad  [0:SQ_STEPS];
    logic signed [DIFF_W-1:0] r_sq_dx   [0:SQ_STEPS];
    logic signed [DIFF_W-1:0] r_sq_dy   [0:SQ_STEPS];
    logic [SQ_REM_W-1:0]      n_sq_rem  [1:SQ_STEPS];
    logic [DIFF_W-1:0]        n_sq_root [1:SQ_STEPS];
    // p0: extension
    logic [DIFF_W-1:0]        r_p0_len, r_p0_aext;
    logic                     r_p0_kill, r_p0_pos;
    logic signed [DIFF_W-1:0] r_p0_dx, r_p0_dy;
    // p1: k * |ext|
    logic [MK_W-1:0]          r_p1_mk;
    logic [DIFF_W-1:0]        r_p1_len, r_p1_ax, r_p1_ay;
    logic                     r_p1_kill, r_p1_negx, r_p1_negy;
    // p2: partial products
    logic [MK_W-1:0]          r_p2_xl, r_p2_yl;
    logic [MK_W:0]            r_p2_xh, r_p2_yh;
    logic [DIFF_W-1:0]        r_p2_len;
    logic                     r_p2_kill, r_p2_negx, r_p2_negy;
    // p3: numerators
    logic [NUM_W-1:0]         r_p3_nx, r_p3_ny;
    logic [DW-1:0]            r_p3_d;
    logic                     r_p3_kill, r_p3_negx, r_p3_negy;
    // divider chain, entry 0 is the overflow check stage
    logic [DW-1:0]            r_dv_rem  [0:DV_STEPS][0:1];
    logic [WORD_W-1:0]        r_dv_num  [0:DV_STEPS][0:1];
    logic [WORD_W-1:0]        r_dv_q    [0:DV_STEPS][0:1];
    logic                     r_dv_ovf  [0:DV_STEPS][0:1];
    logic                     r_dv_neg  [0:DV_STEPS][0:1];
    logic [DW-1:0]            r_dv_d    [0:DV_STEPS];
    logic                     r_dv_kill [0:DV_STEPS];
    logic [DW-1:0]            n_dv_rem  [1:DV_STEPS][0:1];
    logic [WORD_W-1:0]        n_dv_q    [1:DV_STEPS][0:1];
    // output
    logic [WORD_W-1:0]        r_o_fx, r_o_fy;
    logic                     r_o_app, r_o_sat;

    logic signed [DIFF_W-1:0] a_dx, a_dy;
    logic [DIFF_W-1:0]        b_ax, b_ay;
    logic [DIFF_W-1:0]        p0_len;
    logic                     p0_pos;
    logic [WORD_W-1:0]        o_mag [0:1];
    logic [WORD_W-1:0]        o_lim [0:1];
    logic                     o_sat [0:1];
    logic [WORD_W-1:0]        o_val [0:1];

    assign a_dx = $signed({s_axis_tdata[31], s_axis_tdata[31:0]})
                - $signed({s_axis_tdata[95], s_axis_tdata[95:64]});
    assign a_dy = $signed({s_axis_tdata[63], s_axis_tdata[63:32]})
                - $signed({s_axis_tdata[127], s_axis_tdata[127:96]});
    assign b_ax = r_a_dx[DIFF_W-1] ? DIFF_W'(-r_a_dx) : DIFF_W'(r_a_dx);
    assign b_ay = r_a_dy[DIFF_W-1] ? DIFF_W'(-r_a_dy) : DIFF_W'(r_a_dy);

    assign p0_len = r_sq_root[SQ_STEPS];
    assign p0_pos = p0_len > {1'b0, r_l0};

    always_comb begin
        logic [SQ_REM_W-1:0] t_rem;
        logic [SQ_REM_W-1:0] t_trial;
        for (int i = 1; i <= SQ_STEPS; i++) begin
            t_rem   = {r_sq_rem[i-1][SQ_REM_W-3:0], r_sq_rad[i-1][SUMSQ_W-1 -: 2]};
            t_trial = {1'b0, r_sq_root[i-1], 2'b01};
            if (t_rem >= t_trial) begin
                n_sq_rem[i]  = t_rem - t_trial;
                n_sq_root[i] = {r_sq_root[i-1][DIFF_W-2:0], 1'b1};
            end else begin
                n_sq_rem[i]  = t_rem;
                n_sq_root[i] = {r_sq_root[i-1][DIFF_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        logic [DW:0] t_rem;
        for (int i = 1; i <= DV_STEPS; i++) begin
            for (int c = 0; c < 2; c++) begin
                t_rem = {r_dv_rem[i-1][c], r_dv_num[i-1][c][WORD_W-1]};
                if (t_rem >= {1'b0, r_dv_d[i-1]}) begin
                    n_dv_rem[i][c] = DW'(t_rem - {1'b0, r_dv_d[i-1]});
                    n_dv_q[i][c]   = {r_dv_q[i-1][c][WORD_W-2:0], 1'b1};
                end else begin
                    n_dv_rem[i][c] = t_rem[DW-1:0];
                    n_dv_q[i][c]   = {r_dv_q[i-1][c][WORD_W-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            o_mag[c] = r_dv_q[DV_STEPS][c];
            o_lim[c] = r_dv_neg[DV_STEPS][c] ? NEG_LIMIT : POS_LIMIT;
            o_sat[c] = r_dv_ovf[DV_STEPS][c] || (o_mag[c] > o_lim[c]);
            o_val[c] = o_sat[c] ? o_lim[c] : o_mag[c];
            if (r_dv_neg[DV_STEPS][c]) begin
                o_val[c] = -o_val[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_dx <= a_dx;
            r_a_dy <= a_dy;

            r_b_dx <= r_a_dx;
            r_b_dy <= r_a_dy;
            r_b_sx <= b_ax * b_ax;
            r_b_sy <= b_ay * b_ay;

            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_rad[0]  <= r_b_sx + r_b_sy;
            r_sq_dx[0]   <= r_b_dx;
            r_sq_dy[0]   <= r_b_dy;
            for (int i = 1; i <= SQ_STEPS; i++) begin
                r_sq_rem[i]  <= n_sq_rem[i];
                r_sq_root[i] <= n_sq_root[i];
                r_sq_rad[i]  <= {r_sq_rad[i-1][SUMSQ_W-3:0], 2'b00};
                r_sq_dx[i]   <= r_sq_dx[i-1];
                r_sq_dy[i]   <= r_sq_dy[i-1];
            end

            r_p0_len  <= p0_len;
            r_p0_pos  <= p0_pos;
            r_p0_aext <= p0_pos ? (p0_len - {1'b0, r_l0}) : ({1'b0, r_l0} - p0_len);
            r_p0_kill <= (p0_len == '0) || (r_bungee && !p0_pos);
            r_p0_dx   <= r_sq_dx[SQ_STEPS];
            r_p0_dy   <= r_sq_dy[SQ_STEPS];

            r_p1_mk   <= r_k * r_p0_aext;
            r_p1_len  <= r_p0_len;
            r_p1_kill <= r_p0_kill;
            r_p1_ax   <= r_p0_dx[DIFF_W-1] ? DIFF_W'(-r_p0_dx) : DIFF_W'(r_p0_dx);
            r_p1_ay   <= r_p0_dy[DIFF_W-1] ? DIFF_W'(-r_p0_dy) : DIFF_W'(r_p0_dy);
            r_p1_negx <= r_p0_pos == (r_p0_dx > 0);
            r_p1_negy <= r_p0_pos == (r_p0_dy > 0);

            r_p2_xl   <= r_p1_mk[31:0] * r_p1_ax;
            r_p2_xh   <= r_p1_mk[MK_W-1:32] * r_p1_ax;
            r_p2_yl   <= r_p1_mk[31:0] * r_p1_ay;
            r_p2_yh   <= r_p1_mk[MK_W-1:32] * r_p1_ay;
            r_p2_len  <= r_p1_len;
            r_p2_kill <= r_p1_kill;
            r_p2_negx <= r_p1_negx;
            r_p2_negy <= r_p1_negy;

            r_p3_nx   <= {r_p2_xh, 32'd0} + NUM_W'(r_p2_xl);
            r_p3_ny   <= {r_p2_yh, 32'd0} + NUM_W'(r_p2_yl);
            r_p3_d    <= {r_p2_len, FRAC_BITS'(0)};
            r_p3_kill <= r_p2_kill;
            r_p3_negx <= r_p2_negx;
            r_p3_negy <= r_p2_negy;

            r_dv_rem[0][0] <= r_p3_nx[32 +: DW];
            r_dv_rem[0][1] <= r_p3_ny[32 +: DW];
            r_dv_num[0][0] <= r_p3_nx[31:0];
            r_dv_num[0][1] <= r_p3_ny[31:0];
            r_dv_q[0][0]   <= '0;
            r_dv_q[0][1]   <= '0;
            r_dv_ovf[0][0] <= r_p3_nx >= NUM_W'({r_p3_d, 32'd0});
            r_dv_ovf[0][1] <= r_p3_ny >= NUM_W'({r_p3_d, 32'd0});
            r_dv_neg[0][0] <= r_p3_negx;
            r_dv_neg[0][1] <= r_p3_negy;
            r_dv_d[0]      <= r_p3_d;
            r_dv_kill[0]   <= r_p3_kill;
            for (int i = 1; i <= DV_STEPS; i++) begin
                for (int c = 0; c < 2; c++) begin
                    r_dv_rem[i][c] <= n_dv_rem[i][c];
                    r_dv_q[i][c]   <= n_dv_q[i][c];
                    r_dv_num[i][c] <= {r_dv_num[i-1][c][WORD_W-2:0], 1'b0};
                    r_dv_ovf[i][c] <= r_dv_ovf[i-1][c];
                    r_dv_neg[i][c] <= r_dv_neg[i-1][c];
                end
                r_dv_d[i]    <= r_dv_d[i-1];
                r_dv_kill[i] <= r_dv_kill[i-1];
            end

            if (r_dv_kill[DV_STEPS]) begin
                r_o_fx  <= '0;
                r_o_fy  <= '0;
                r_o_app <= 1'b0;
                r_o_sat <= 1'b0;
            end else begin
                r_o_fx  <= o_val[0];
                r_o_fy  <= o_val[1];
                r_o_app <= 1'b1;
                r_o_sat <= o_sat[0] || o_sat[1];
            end
        end
    end

    assign m_axis_tdata = {r_o_fy, r_o_fx};
    assign m_axis_tuser = {r_o_sat, r_o_app};

`ifndef ASSERT_OFF
    a_slack_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
        else $error("force without applied flag");

    a_sat_is_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            m_axis_tdata[31:0] == POS_LIMIT || m_axis_tdata[31:0] == NEG_LIMIT ||
            m_axis_tdata[63:32] == POS_LIMIT || m_axis_tdata[63:32] == NEG_LIMIT)
        else $error("saturated flag without clipped component");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_vld[0])
        else $error("accepted request not in pipe");
`endif

endmodule

`default_nettype wire

>>> bench/spring_bungee_force_tb.sv
`timescale 1ns / 1ps

module spring_bungee_force_tb;
    import sbf_pkg::*;

    localparam int FRAC = 16;
    localparam int LATENCY = 74;
    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 2000;

    typedef struct packed {
        logic signed [31:0] py;
        logic signed [31:0] px;
        logic signed [31:0] qy;
        logic signed [31:0] qx;
    } t_pos;

    typedef struct {
        logic [31:0] fx;
        logic [31:0] fy;
        logic applied;
        logic sat;
    } t_force;

    typedef struct {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] qx;
        logic [31:0] qy;
        logic [31:0] fx;
        logic [31:0] fy;
        logic [1:0] flags;
        bit typed;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    logic [31:0] k_reg;
    logic [31:0] l0_reg;
    logic bungee_reg;

    t_force expected_forces[$];
    int mismatches;
    int idle_cycles;
    bit timed_out;
    bit hold_off;
    bit stim_done;

    spring_bungee_force #(.FRAC_BITS(FRAC)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [32:0] isqrt(logic [65:0] v);
        logic [35:0] rem;
        logic [32:0] root;
        logic [35:0] trial;
        rem = '0;
        root = '0;
        for (int i = 32; i >= 0; i--) begin
            rem = {rem[33:0], v[2*i+1 -: 2]};
            trial = {1'b0, root, 2'b01};
            if (rem >= trial) begin
                rem = rem - trial;
                root = {root[31:0], 1'b1};
            end else begin
                root = {root[31:0], 1'b0};
            end
        end
        return root;
    endfunction

    function automatic logic [31:0] force_axis(logic signed [33:0] d, logic [64:0] kext,
                                               bit ext_pos, bit ext_zero,
                                               logic [32:0] len, ref logic sat);
        logic [33:0] ad;
        logic [98:0] num;
        logic [98:0] quo;
        logic [48:0] den;
        logic [31:0] limit;
        bit neg;
        if (d == 0 || ext_zero) return 32'd0;
        ad = (d < 0) ? -d : d;
        num = kext * ad;
        den = {len, 16'd0};
        quo = num / den;
        neg = (ext_pos == (d > 0));
        limit = neg ? NEG_LIMIT : POS_LIMIT;
        if (quo > limit) begin
            sat = 1'b1;
            quo = limit;
        end
        return neg ? -quo[31:0] : quo[31:0];
    endfunction

    function automatic t_force spring_force(t_pos p);
        t_force f;
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        logic [33:0] ax;
        logic [33:0] ay;
        logic [65:0] sumsq;
        logic [32:0] len;
        logic [32:0] aext;
        logic [64:0] kext;
        logic sat;
        f.fx = '0;
        f.fy = '0;
        f.applied = 1'b0;
        f.sat = 1'b0;
        dx = 34'(p.px) - 34'(p.qx);
        dy = 34'(p.py) - 34'(p.qy);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        sumsq = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
        len = isqrt(sumsq);
        if (len == 0) return f;
        if (bungee_reg && len <= {1'b0, l0_reg}) return f;
        aext = (len > l0_reg) ? len - l0_reg : l0_reg - len;
        kext = 65'(k_reg) * 65'(aext);
        sat = 1'b0;
        f.fx = force_axis(dx, kext, len > l0_reg, len == l0_reg, len, sat);
        f.fy = force_axis(dy, kext, len > l0_reg, len == l0_reg, len, sat);
        f.applied = 1'b1;
        f.sat = sat;
        return f;
    endfunction

    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_SPRING_K: k_reg = value;
            REG_REST_LEN: l0_reg = value;
            REG_BUNGEE: bungee_reg = value[0];
            default: ;
        endcase
    endtask

    task automatic send_request(t_pos p, t_force f);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {p.qy, p.qx, p.py, p.px};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_forces = {expected_forces, f};
    endtask

    task automatic idle_sender(int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_forces.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            2: return $urandom_range(0, 2) ? 32'h7fff_ffff - $urandom_range(0, 255)
                                           : 32'h8000_0000 + $urandom_range(0, 255);
            default: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
        endcase
    endfunction

    task automatic run_random(int count);
        t_pos p;
        int burst;
        for (int n = 0; n < count; ) begin
            burst = $urandom_range(1, 30);
            for (int b = 0; b < burst && n < count; b++, n++) begin
                p.px = rand_coord($urandom_range(0, 3));
                p.py = rand_coord($urandom_range(0, 3));
                if ($urandom_range(0, 9) == 0) begin
                    p.qx = p.px;
                    p.qy = p.py;
                end else begin
                    p.qx = rand_coord($urandom_range(0, 3));
                    p.qy = rand_coord($urandom_range(0, 3));
                end
                send_request(p, spring_force(p));
            end
            if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 12));
        end
    endtask

    // receiver stall pattern
    initial begin
        m_axis_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off) m_axis_tready <= 1'b0;
            else if (stim_done) m_axis_tready <= 1'b1;
            else m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // result checker and watchdog
    always @(posedge i_clk) begin
        t_force e;
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || psel)
                idle_cycles <= 0;
            else if (!hold_off)
                idle_cycles <= idle_cycles + 1;
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_forces.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
                end else begin
                    e = expected_forces.pop_front();
                    if (m_axis_tdata[31:0] !== e.fx || m_axis_tdata[63:32] !== e.fy
                            || m_axis_tuser !== {e.sat, e.applied}) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp fx %h fy %h flags %b, got %h %h %b",
                                     e.fx, e.fy, {e.sat, e.applied}, m_axis_tdata[31:0],
                                     m_axis_tdata[63:32], m_axis_tuser);
                    end
                end
            end
        end
    end

    initial begin
        wait (i_rst_n);
        wait (idle_cycles >= IDLE_LIMIT);
        timed_out = 1'b1;
        $display("[spring_bungee_force] ERROR");
        $finish;
    end

    initial begin
        t_row rows [10];
        t_row r;
        t_pos p;
        t_force f;
        mismatches = 0;
        timed_out = 1'b0;
        hold_off = 1'b0;
        stim_done = 1'b0;
        k_reg = K_RESET;
        l0_reg = '0;
        bungee_reg = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, typed rows use reset registers
        rows[0] = '{0, 0, 0, 0, 0, 0, 2'b00, 1};
        rows[1] = '{32'h0001_0000, 0, 0, 0, 32'hffff_0000, 0, 2'b01, 1};
        rows[2] = '{0, 32'h0003_0000, 0, 0, 0, 32'hfffd_0000, 2'b01, 1};
        rows[3] = '{32'h7fff_ffff, 32'h1234, 32'h7fff_ffff, 32'h1234, 0, 0, 2'b00, 1};
        rows[4] = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000, 2'b11, 1};
        rows[5] = '{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                    32'h7fff_ffff, 32'h7fff_ffff, 2'b11, 1};
        rows[6] = '{32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 0, 0};
        rows[7] = '{32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 0, 0, 0, 0, 0};
        rows[8] = '{1, 0, 0, 0, 0, 0, 0, 0};
        rows[9] = '{32'h8000_0000, 0, 0, 0, 0, 0, 0, 0};
        foreach (rows[i]) begin
            r = rows[i];
            p.px = r.px;
            p.py = r.py;
            p.qx = r.qx;
            p.qy = r.qy;
            if (r.typed) begin
                f.fx = r.fx;
                f.fy = r.fy;
                f.applied = r.flags[0];
                f.sat = r.flags[1];
            end else begin
                f = spring_force(p);
            end
            send_request(p, f);
        end
        drain_results();

        // rest length equals distance 5.0, spring mode then bungee
        apb_write(REG_REST_LEN, 32'h0005_0000);
        apb_write(REG_SPRING_K, 32'h0002_0000);
        for (int m = 0; m < 2; m++) begin
            p = '{py: 32'h0004_0000, px: 32'h0003_0000, qy: 0, qx: 0};
            send_request(p, spring_force(p));
            p = '{py: 0, px: 32'h0001_0000, qy: 0, qx: 0};
            send_request(p, spring_force(p));
            p = '{py: 0, px: 32'h0009_0000, qy: 0, qx: 0};
            send_request(p, spring_force(p));
            drain_results();
            apb_write(REG_BUNGEE, 32'hffff_ffff);
        end

        // configuration sweep with random traffic
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin apb_write(REG_SPRING_K, 32'hffff_ffff); apb_write(REG_REST_LEN, 0); end
                1: begin apb_write(REG_SPRING_K, 0); apb_write(REG_REST_LEN, 32'hffff_ffff); end
                2: begin apb_write(REG_SPRING_K, 1); apb_write(REG_BUNGEE, 0); end
                3: begin
                    apb_write(REG_SPRING_K, $urandom());
                    apb_write(REG_REST_LEN, $urandom_range(0, 32'h0080_0000));
                end
                4: apb_write(REG_BUNGEE, 1);
                default: begin
                    apb_write(REG_SPRING_K, $urandom_range(0, 32'h0004_0000));
                    apb_write(REG_REST_LEN, $urandom_range(0, 32'h0100_0000));
                    apb_write(REG_BUNGEE, $urandom_range(0, 1));
                end
            endcase
            if (phase == 3) begin
                // long receiver hold-off while the sender keeps offering
                fork
                    run_random(RANDOM_ITEMS / 8);
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                join
            end else begin
                run_random(RANDOM_ITEMS / 8);
            end
            drain_results();
        end

        stim_done = 1'b1;
        repeat (LATENCY + 10) @(posedge i_clk);
        if (!timed_out && mismatches == 0 && expected_forces.size() == 0) begin
            $display("[spring_bungee_force] OK");
        end else begin
            $display("[spring_bungee_force] ERROR");
        end
        $finish;
    end

endmodule
